@@ design/adpcm_nd_pkg.sv @@
// Shared types, constants and helper functions for the ADPCM nibble decoder.
// Used by every module of the block; depends on nothing else.
package adpcm_nd_pkg;

  // Input queue and output queue depths
  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  // Reset value of the initial step register
  localparam logic [15:0] INIT_STEP_RESET = 16'd16;

  // Zero level of the unsigned PCM output
  localparam logic [7:0] SAMPLE_BIAS = 8'd128;

  // Step adaptation factors, scaled by 256
  localparam int FACTOR_W = 10;
  localparam logic [FACTOR_W-1:0] FACTOR_SMALL = 10'd233;
  localparam logic [FACTOR_W-1:0] FACTOR_MAG4  = 10'd310;
  localparam logic [FACTOR_W-1:0] FACTOR_MAG5  = 10'd375;
  localparam logic [FACTOR_W-1:0] FACTOR_MAG6  = 10'd453;
  localparam logic [FACTOR_W-1:0] FACTOR_MAG7  = 10'd549;
  localparam int FACTOR_SHIFT = 8;

  // Offset of the binary code
  localparam logic [3:0] CODE_OFFSET = 4'd8;

  // Decode phase of one code byte
  typedef enum logic [1:0] {
    PH_HI = 2'b01,
    PH_LO = 2'b10
  } phase_t;

  // One classified nibble: direction and magnitude (0..8)
  typedef struct packed {
    logic       neg;
    logic [3:0] mag;
  } nib_cls_t;

  // One queued code byte, already classified
  typedef struct packed {
    logic     restart;
    nib_cls_t hi;
    nib_cls_t lo;
  } fq_entry_t;

  // Valid and pair position of a word moving down the sample pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

  // Occupancy of the sample pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_busy_t;

  // One result word
  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } out_word_t;

  // Split a 4-bit offset-binary code into direction and magnitude
  function automatic nib_cls_t classify(input logic [3:0] code);
    nib_cls_t c;
    c.neg = ~code[3];
    if (code[3]) begin
      c.mag = code - CODE_OFFSET;
    end else begin
      c.mag = CODE_OFFSET - code;
    end
    return c;
  endfunction

  // Step adaptation factor for a magnitude
  function automatic logic [FACTOR_W-1:0] factor_for(input logic [3:0] mag);
    logic [FACTOR_W-1:0] f;
    case (mag)
      4'd4: f = FACTOR_MAG4;
      4'd5: f = FACTOR_MAG5;
      4'd6: f = FACTOR_MAG6;
      4'd7, 4'd8: f = FACTOR_MAG7;
      default: f = FACTOR_SMALL;
    endcase
    return f;
  endfunction

endpackage

@@ design/adpcm_nibble_decoder.sv @@
// ADPCM nibble decoder top level: queue, core, sample pipeline, output queue.
// The core retires one nibble per cycle while the output queue has room, taking
// the high nibble of each queued byte before the low one. A sample passes the
// input queue, the accumulator register, sample stages s1 and s2 and the output
// queue. Reset (rst, synchronous): empties both queues, clears the
// accumulator, and sets initial step and step size to 16.
module adpcm_nibble_decoder
  import adpcm_nd_pkg::*;
#(
  parameter int ACC_WIDTH  = 32,
  parameter int STEP_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  code_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  sample,
  output logic        last_of_pair
);

  logic                 q_valid;
  fq_entry_t            q_head;
  logic                 q_pop;
  logic                 credit_ok;
  logic [ACC_WIDTH-1:0] acc;
  pipe_ctl_t            acc_ctl;
  pipe_busy_t           busy;
  logic                 push;
  out_word_t            push_word;
  logic [OQ_AW:0]       oq_count;
  logic [OQ_AW:0]       occupancy;
  out_word_t            head;

  assign cfg_ready = 1'b1;

  adpcm_nd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .code_byte (code_byte),
    .restart   (restart),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  adpcm_nd_core #(
    .ACC_WIDTH  (ACC_WIDTH),
    .STEP_WIDTH (STEP_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .credit_ok (credit_ok),
    .acc       (acc),
    .acc_ctl   (acc_ctl)
  );

  adpcm_nd_sample #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_sample (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .acc_ctl   (acc_ctl),
    .busy      (busy),
    .push      (push),
    .push_word (push_word)
  );

  adpcm_nd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .count     (oq_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Issue a nibble only if the output queue has room for every word in flight
  assign occupancy = oq_count + (OQ_AW+1)'(acc_ctl.valid)
                   + (OQ_AW+1)'(busy.s1) + (OQ_AW+1)'(busy.s2);
  assign credit_ok = (occupancy < (OQ_AW+1)'(OQ_DEPTH));

  assign sample       = head.sample;
  assign last_of_pair = head.last;

  // Words in flight never exceed the output queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("output queue over-committed");

  // The core retires a queued word only when one is present
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty input queue");

  // An accumulator update reaches the first sample stage in the next cycle
  a_pipe_flow: assert property (@(posedge clk) disable iff (rst)
    acc_ctl.valid |=> busy.s1)
    else $error("sample pipeline dropped a word");

  // A high-nibble issue is never directly followed by another high-nibble issue
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (acc_ctl.valid && !acc_ctl.last) |=> !(acc_ctl.valid && !acc_ctl.last))
    else $error("two high-nibble words in a row");

endmodule

@@ design/adpcm_nd_front.sv @@
// Front end of the ADPCM nibble decoder: accepts code bytes, classifies both
// nibbles and holds them in a short queue. Depends on adpcm_nd_pkg.
module adpcm_nd_front
  import adpcm_nd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] code_byte,
  input  logic       restart,
  output logic       q_valid,
  output fq_entry_t  q_head,
  input  logic       q_pop
);

  fq_entry_t        fq [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr;
  logic [FQ_AW-1:0] rd_ptr;
  logic [FQ_AW:0]   count;
  logic             push;
  logic             pop;

  assign in_stall = (count == (FQ_AW+1)'(FQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_head   = fq[rd_ptr];

  // Store the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      fq[wr_ptr] <= '{restart: restart,
                      hi: classify(code_byte[7:4]),
                      lo: classify(code_byte[3:0])};
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (FQ_AW+1)'(1);
        2'b01:   count <= count - (FQ_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/adpcm_nd_core.sv @@
// Back-end core of the ADPCM nibble decoder: steps through the two nibbles of
// each queued word, updating accumulator and step size. Depends on adpcm_nd_pkg.
module adpcm_nd_core
  import adpcm_nd_pkg::*;
#(
  parameter int ACC_WIDTH  = 32,
  parameter int STEP_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [15:0]          cfg_data,
  input  logic                 q_valid,
  input  fq_entry_t            q_head,
  output logic                 q_pop,
  input  logic                 credit_ok,
  output logic [ACC_WIDTH-1:0] acc,
  output pipe_ctl_t            acc_ctl
);

  localparam logic [STEP_WIDTH-1:0] STEP_MAX = {STEP_WIDTH{1'b1}};

  logic [15:0]             initial_step;
  logic [STEP_WIDTH-1:0]   init_sat;
  logic [STEP_WIDTH-1:0]   step;
  logic [STEP_WIDTH-1:0]   step_next;
  logic [ACC_WIDTH-1:0]    acc_next;
  phase_t                  phase;
  phase_t                  phase_next;
  logic                    issue;
  logic                    do_restart;
  nib_cls_t                cls;
  logic [ACC_WIDTH-1:0]    acc_base;
  logic [STEP_WIDTH-1:0]   step_base;
  logic [STEP_WIDTH+3:0]   delta;
  logic [ACC_WIDTH-1:0]    delta_ext;
  logic [STEP_WIDTH+FACTOR_W-1:0] prod;
  logic [STEP_WIDTH+1:0]   scaled;

  // Hold the initial step register
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_step <= INIT_STEP_RESET;
    end else if (cfg_valid) begin
      initial_step <= cfg_data;
    end
  end

  // Saturate the initial step to the step width
  always_comb begin
    if (32'(initial_step) > 32'(STEP_MAX)) begin
      init_sat = STEP_MAX;
    end else begin
      init_sat = STEP_WIDTH'(initial_step);
    end
  end

  // Select the nibble and the starting state for this cycle
  always_comb begin
    issue      = q_valid && credit_ok;
    do_restart = 1'b0;
    cls        = q_head.hi;
    phase_next = phase;
    q_pop      = 1'b0;
    case (phase)
      PH_HI: begin
        do_restart = q_head.restart;
        cls        = q_head.hi;
        if (issue) begin
          phase_next = PH_LO;
        end
      end
      PH_LO: begin
        cls = q_head.lo;
        if (issue) begin
          phase_next = PH_HI;
          q_pop      = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HI;
      end
    endcase
  end

  // Accumulate the scaled delta and adapt the step
  always_comb begin
    acc_base  = do_restart ? '0 : acc;
    step_base = do_restart ? init_sat : step;
    delta     = (STEP_WIDTH+4)'(step_base) * (STEP_WIDTH+4)'(cls.mag);
    delta_ext = ACC_WIDTH'(delta);
    acc_next  = cls.neg ? (acc_base - delta_ext) : (acc_base + delta_ext);
    prod      = (STEP_WIDTH+FACTOR_W)'(step_base)
              * (STEP_WIDTH+FACTOR_W)'(factor_for(cls.mag));
    scaled    = prod[STEP_WIDTH+FACTOR_W-1:FACTOR_SHIFT];
    if (scaled[STEP_WIDTH+1:STEP_WIDTH] != 2'b00) begin
      step_next = STEP_MAX;
    end else begin
      step_next = scaled[STEP_WIDTH-1:0];
    end
  end

  // Advance state on each issued nibble
  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      step          <= STEP_WIDTH'(INIT_STEP_RESET);
      phase         <= PH_HI;
      acc_ctl.valid <= 1'b0;
      acc_ctl.last  <= 1'b0;
    end else begin
      phase         <= phase_next;
      acc_ctl.valid <= issue;
      if (issue) begin
        acc          <= acc_next;
        step         <= step_next;
        acc_ctl.last <= (phase == PH_LO);
      end
    end
  end

endmodule

@@ design/adpcm_nd_sample.sv @@
// Sample pipeline of the ADPCM nibble decoder: turns the accumulator into an
// 8-bit PCM sample (accumulator / 258 + 128). Depends on adpcm_nd_pkg.
module adpcm_nd_sample
  import adpcm_nd_pkg::*;
#(
  parameter int ACC_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ACC_WIDTH-1:0] acc,
  input  pipe_ctl_t            acc_ctl,
  output pipe_busy_t           busy,
  output logic                 push,
  output out_word_t            push_word
);

  // Divide by 258 as a halving then a divide by 129; 2^14 is 1 mod 129 and
  // 129 is its own inverse mod 256, so only the quotient's low byte is built.
  localparam int CHUNK_W  = 14;
  localparam int MOD_BASE = 129;
  localparam int XW       = ACC_WIDTH - 1;
  localparam int NCH      = (XW + CHUNK_W - 1) / CHUNK_W;
  localparam int PW       = NCH * CHUNK_W;
  localparam int SUM_W    = $clog2(NCH * (1 << CHUNK_W));
  localparam int FOLD_W   = CHUNK_W + 1;

  logic [ACC_WIDTH-1:0] acc_abs;
  logic                 s1_v;
  logic                 s1_last;
  logic                 s1_neg;
  logic [XW-1:0]        s1_x;
  logic [PW-1:0]        x_pad;
  logic [SUM_W-1:0]     chunk_sum;
  logic                 s2_v;
  logic                 s2_last;
  logic                 s2_neg;
  logic [7:0]           s2_x8;
  logic [SUM_W-1:0]     s2_sum;
  logic [FOLD_W-1:0]    fold;
  logic [8:0]           rdiff;
  logic [7:0]           rem;
  logic [7:0]           diff8;
  logic [7:0]           quo8;

  // Take the magnitude of the accumulator
  assign acc_abs = acc[ACC_WIDTH-1] ? (~acc + ACC_WIDTH'(1)) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= acc_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_last <= acc_ctl.last;
    s1_neg  <= acc[ACC_WIDTH-1];
    s1_x    <= acc_abs[ACC_WIDTH-1:1];
  end

  // Sum the 14-bit chunks of the halved magnitude
  always_comb begin
    x_pad     = PW'(s1_x);
    chunk_sum = '0;
    for (int i = 0; i < NCH; i++) begin
      chunk_sum = chunk_sum + SUM_W'(x_pad[i*CHUNK_W +: CHUNK_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_last <= s1_last;
    s2_neg  <= s1_neg;
    s2_x8   <= s1_x[7:0];
    s2_sum  <= chunk_sum;
  end

  // Reduce mod 129, recover the quotient's low byte and bias it
  always_comb begin
    fold  = FOLD_W'(s2_sum[CHUNK_W-1:0]) + FOLD_W'(s2_sum[SUM_W-1:CHUNK_W]);
    rdiff = {2'b00, fold[6:0]} - {1'b0, fold[14:7]};
    if (rdiff[8]) begin
      rem = 8'(rdiff + 9'(MOD_BASE));
    end else begin
      rem = rdiff[7:0];
    end
    diff8 = s2_x8 - rem;
    quo8  = diff8 + {diff8[0], 7'b0};
    push_word.last = s2_last;
    if (s2_neg) begin
      push_word.sample = SAMPLE_BIAS - quo8;
    end else begin
      push_word.sample = quo8 + SAMPLE_BIAS;
    end
  end

  assign push    = s2_v;
  assign busy.s1 = s1_v;
  assign busy.s2 = s2_v;

endmodule

@@ design/adpcm_nd_outq.sv @@
// Output queue of the ADPCM nibble decoder: buffers finished sample words
// toward the stall-driven output. Depends on adpcm_nd_pkg.
module adpcm_nd_outq
  import adpcm_nd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  out_word_t      push_word,
  output logic [OQ_AW:0] count,
  output logic           out_valid,
  input  logic           out_stall,
  output out_word_t      head
);

  out_word_t        oq [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic             pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = oq[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      oq[wr_ptr] <= push_word;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (OQ_AW+1)'(1);
        2'b01:   count <= count - (OQ_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sim/adpcm_nibble_decoder_tb.sv @@
// Self-checking testbench for adpcm_nibble_decoder: drives code bytes with random gaps and
// output stalls, predicts both PCM samples of every accepted byte, and checks them in order.
// Depends only on the RTL of the block; the initial step register goes through several values.
module adpcm_nibble_decoder_tb;

  localparam int unsigned STEP_LIMIT   = 65535;
  localparam logic [15:0] STEP_AT_RST  = 16'd16;
  localparam logic [31:0] LEVEL_DIV    = 32'd258;
  localparam logic [7:0]  LEVEL_ZERO   = 8'd128;
  localparam logic [3:0]  CODE_MID     = 4'd8;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          RANDOM_RUN   = 300;
  localparam int          DRIFT_RUN    = 180;

  // One code byte waiting to be sent
  typedef struct packed {
    logic [7:0] code;
    logic       restart;
  } code_word_t;

  // One predicted PCM sample
  typedef struct packed {
    logic [7:0] level;
    logic       last;
  } pcm_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  code_byte = '0;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  sample;
  logic        last_of_pair;

  code_word_t code_backlog[$];
  pcm_word_t  pcm_expected[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int fail_count    = 0;
  int bytes_sent    = 0;
  int samples_seen  = 0;
  int step_settings = 0;

  // Predictor state
  logic [31:0] acc_track;
  logic [15:0] step_track;
  logic [15:0] init_step_track;

  adpcm_nibble_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_byte   (code_byte),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .last_of_pair(last_of_pair)
  );

  always #4 clk = ~clk;

  // Step adaptation factor over 256 for a code magnitude
  function automatic logic [31:0] step_gain(input logic [3:0] mag);
    case (mag)
      4'd4: return 32'd310;
      4'd5: return 32'd375;
      4'd6: return 32'd453;
      4'd7, 4'd8: return 32'd549;
      default: return 32'd233;
    endcase
  endfunction

  // Apply one nibble to the accumulator and step, return the PCM level
  function automatic logic [7:0] decode_code(input logic [3:0] code);
    logic [3:0]  mag;
    logic [31:0] delta;
    logic [31:0] quot;
    logic [31:0] scaled;
    logic [7:0]  level;
    if (code >= CODE_MID) begin
      mag = code - CODE_MID;
      delta = 32'(step_track) * 32'(mag);
      acc_track = acc_track + delta;
    end else begin
      mag = CODE_MID - code;
      delta = 32'(step_track) * 32'(mag);
      acc_track = acc_track - delta;
    end
    // Divide toward zero: work on the magnitude, then restore the sign
    if (acc_track[31]) begin
      quot = (32'd0 - acc_track) / LEVEL_DIV;
      level = LEVEL_ZERO - quot[7:0];
    end else begin
      quot = acc_track / LEVEL_DIV;
      level = LEVEL_ZERO + quot[7:0];
    end
    scaled = (32'(step_track) * step_gain(mag)) >> 8;
    step_track = (scaled > STEP_LIMIT) ? 16'(STEP_LIMIT) : scaled[15:0];
    return level;
  endfunction

  // Sender: hold a stalled word, otherwise advance to the next one or idle
  always @(posedge clk) begin
    code_word_t next_word;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (code_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = code_backlog.pop_front();
        in_valid  <= 1'b1;
        code_byte <= next_word.code;
        restart   <= next_word.restart;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Predict on every accepted byte, check every accepted sample
  always @(posedge clk) begin
    pcm_word_t want;
    if (rst) begin
      acc_track       = '0;
      init_step_track = STEP_AT_RST;
      step_track      = STEP_AT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        init_step_track = cfg_data;
      end
      if (out_valid && !out_stall) begin
        samples_seen++;
        if (pcm_expected.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected sample %0d last_of_pair %0b", $time, sample, last_of_pair);
        end else begin
          want = pcm_expected.pop_front();
          if (sample !== want.level) begin
            fail_count++;
            $display("%0t: sample expected %0d actual %0d", $time, want.level, sample);
          end
          if (last_of_pair !== want.last) begin
            fail_count++;
            $display("%0t: last_of_pair expected %0b actual %0b", $time, want.last,
                     last_of_pair);
          end
        end
      end
      if (in_valid && !in_stall) begin
        bytes_sent++;
        if (restart) begin
          acc_track  = '0;
          step_track = init_step_track;
        end
        want.last  = 1'b0;
        want.level = decode_code(code_byte[7:4]);
        pcm_expected.push_back(want);
        want.last  = 1'b1;
        want.level = decode_code(code_byte[3:0]);
        pcm_expected.push_back(want);
      end
    end
  end

  task automatic queue_byte(input logic [7:0] code, input logic rs);
    code_word_t w;
    w.code    = code;
    w.restart = rs;
    code_backlog.push_back(w);
  endtask

  // Wait until every sent word has been decoded and every sample checked
  task automatic drain_pipeline();
    do @(negedge clk); while (code_backlog.size() != 0 || in_valid || pcm_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_initial_step(input logic [15:0] value);
    drain_pipeline();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_settings++;
  endtask

  // Code with magnitude 6..8
  function automatic logic [3:0] loud_code();
    return $urandom_range(1) ? 4'($urandom_range(2)) : 4'($urandom_range(15, 14));
  endfunction

  // Code with magnitude 0..3
  function automatic logic [3:0] quiet_code();
    return 4'($urandom_range(11, 5));
  endfunction

  // Streams that restart and then run with loud, quiet, alternating or noisy codes
  task automatic queue_random_run(input int n);
    int left;
    int seg;
    int kind;
    logic [7:0] b;
    logic rs;
    left = n;
    while (left > 0) begin
      seg  = $urandom_range(40, 1);
      kind = $urandom_range(3);
      if (seg > left) seg = left;
      for (int i = 0; i < seg; i++) begin
        case (kind)
          0: b = 8'($urandom);
          1: b = {loud_code(), loud_code()};
          2: b = {quiet_code(), quiet_code()};
          default: b = {loud_code(), quiet_code()};
        endcase
        if (i == 0) begin
          rs = (left == n) || ($urandom_range(1) == 1);
        end else begin
          rs = ($urandom_range(31) == 0);
        end
        queue_byte(b, rs);
      end
      left -= seg;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: every code, extremes, and the step growing into saturation
    send_idle_pct = 18;
    stall_pct     = 56;
    @(negedge clk);
    queue_byte(8'h88, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h23, 1'b0);
    queue_byte(8'h45, 1'b0);
    queue_byte(8'h67, 1'b0);
    queue_byte(8'h89, 1'b0);
    queue_byte(8'hAB, 1'b0);
    queue_byte(8'hCD, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h77, 1'b0);
    repeat (6) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b1);

    // Step of one truncates to zero and stays there
    load_initial_step(16'd1);
    queue_byte(8'h89, 1'b1);
    queue_byte(8'hF0, 1'b0);

    // Zero initial step
    load_initial_step(16'd0);
    queue_byte(8'h0F, 1'b1);
    queue_byte(8'hF0, 1'b0);

    // Largest initial step, saturating at once
    load_initial_step(16'hFFFF);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);

    // Random streams under three idling patterns
    load_initial_step(16'($urandom_range(65535, 1)));
    queue_random_run(RANDOM_RUN);

    load_initial_step(16'($urandom_range(64, 1)));
    send_idle_pct = 56;
    stall_pct     = 18;
    queue_random_run(RANDOM_RUN);

    load_initial_step(16'($urandom_range(65535, 1024)));
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random_run(RANDOM_RUN);

    // Long loud drift at the largest step, driving the accumulator far negative
    load_initial_step(16'hFFFF);
    queue_byte(8'h00, 1'b1);
    for (int i = 1; i < DRIFT_RUN; i++) begin
      queue_byte({3'b000, 1'($urandom), 3'b000, 1'($urandom)}, 1'b0);
    end

    drain_pipeline();
    $display("Decoded %0d code bytes into %0d checked samples", bytes_sent, samples_seen);
    $display("Covered %0d initial step settings, three idling patterns, a saturated drift",
             step_settings);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
